// ===== rtl/core/drrl_pkg.sv =====
// Package for the drift reapply rate limiter: word types, status codes and register constants.
package drrl_pkg;

    localparam int TIME_BITS_DEFAULT = 48;
    localparam int NOW_WIDTH         = 48;
    localparam int CFG_INDEX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH    = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENABLE         = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHECK_INTERVAL = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONFIRM        = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW         = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_PER_WINDOW = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_REQUEUE    = 3'd5;

    localparam logic        RST_ENABLE         = 1'b1;
    localparam logic [31:0] RST_CHECK_INTERVAL = 32'd5000;
    localparam logic [7:0]  RST_CONFIRM        = 8'd3;
    localparam logic [31:0] RST_WINDOW         = 32'd600000;
    localparam logic [7:0]  RST_MAX_PER_WINDOW = 8'd3;
    localparam logic [31:0] RST_MIN_REQUEUE    = 32'd30000;

    typedef enum logic [3:0] {
        STAT_DISABLED  = 4'd0,
        STAT_INTERVAL  = 4'd1,
        STAT_BUSY      = 4'd2,
        STAT_NO_INTENT = 4'd3,
        STAT_NOT_READY = 4'd4,
        STAT_NO_DRIFT  = 4'd5,
        STAT_PENDING   = 4'd6,
        STAT_CAP       = 4'd7,
        STAT_BACKOFF   = 4'd8,
        STAT_QUEUED    = 4'd9
    } status_t;

    typedef struct packed {
        logic [NOW_WIDTH-1:0] now_ms;
        logic                 recovery_busy;
        logic                 has_vf_intent;
        logic                 hw_ready;
        logic                 read_ok;
        logic                 drift_seen;
    } check_word_t;

    typedef struct packed {
        status_t    status;
        logic       reapply;
        logic [7:0] consecutive;
        logic [7:0] queued_in_window;
    } result_word_t;

endpackage

// ===== rtl/core/drift_reapply_rate_limiter.sv =====
// Drift reapply rate limiter: gates periodic drift checks and limits reapply requests.
// An accepted check word goes to the input register, its result word to the result
// register. Throughput is one check word per cycle when res_stall is low; the state
// update of one check is a single compare-and-subtract pass between these registers.
// Reset (rst_n low, asynchronous) loads the register defaults and clears all state.
module drift_reapply_rate_limiter #(
    parameter int TIME_BITS = drrl_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [drrl_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [drrl_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                   chk_valid,
    output logic                                   chk_stall,
    input  drrl_pkg::check_word_t                  chk_word,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output drrl_pkg::result_word_t                 res_word
);
    import drrl_pkg::*;

    typedef logic [TIME_BITS-1:0] time_t;

    localparam int NOW_WIDE_BITS = TIME_BITS + NOW_WIDTH;

    logic        enable_reg;
    logic [31:0] check_interval_reg;
    logic [7:0]  confirm_reg;
    logic [31:0] window_reg;
    logic [7:0]  max_per_window_reg;
    logic [31:0] min_requeue_reg;

    time_t      last_check_reg, last_check_next;
    logic [7:0] drift_count_reg, drift_count_next;
    time_t      window_start_reg, window_start_next;
    logic [7:0] window_count_reg, window_count_next;
    time_t      last_queue_reg, last_queue_next;

    logic         stage_valid_reg;
    check_word_t  stage_word_reg;
    logic         res_valid_reg;
    result_word_t res_word_reg, res_word_next;

    logic  res_free;
    logic  stage_move;
    logic  chk_take;
    logic [NOW_WIDE_BITS-1:0] now_wide;
    time_t now;
    time_t since_check, since_window, since_queue;
    logic [7:0] count_inc;
    logic [7:0] win_count_eff;

    assign res_free   = !res_valid_reg || !res_stall;
    assign stage_move = stage_valid_reg && res_free;
    assign chk_stall  = stage_valid_reg && !res_free;
    assign chk_take   = chk_valid && !chk_stall;
    assign res_valid  = res_valid_reg;
    assign res_word   = res_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= RST_ENABLE;
            check_interval_reg <= RST_CHECK_INTERVAL;
            confirm_reg        <= RST_CONFIRM;
            window_reg         <= RST_WINDOW;
            max_per_window_reg <= RST_MAX_PER_WINDOW;
            min_requeue_reg    <= RST_MIN_REQUEUE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:         enable_reg         <= cfg_data[0];
                CFG_CHECK_INTERVAL: check_interval_reg <= cfg_data;
                CFG_CONFIRM:        confirm_reg        <= cfg_data[7:0];
                CFG_WINDOW:         window_reg         <= cfg_data;
                CFG_MAX_PER_WINDOW: max_per_window_reg <= cfg_data[7:0];
                CFG_MIN_REQUEUE:    min_requeue_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The time field is reduced to (or widened to) the internal time width.
    assign now_wide = {{TIME_BITS{1'b0}}, stage_word_reg.now_ms};
    assign now      = now_wide[TIME_BITS-1:0];

    assign since_check  = now - last_check_reg;
    assign since_window = now - window_start_reg;
    assign since_queue  = now - last_queue_reg;
    assign count_inc    = (drift_count_reg == 8'hFF) ? drift_count_reg : drift_count_reg + 8'd1;

    always_comb
    begin
        last_check_next   = last_check_reg;
        drift_count_next  = drift_count_reg;
        window_start_next = window_start_reg;
        window_count_next = window_count_reg;
        last_queue_next   = last_queue_reg;
        win_count_eff     = window_count_reg;
        res_word_next.status  = STAT_DISABLED;
        res_word_next.reapply = 1'b0;

        priority if (!enable_reg)
        begin
            res_word_next.status = STAT_DISABLED;
        end
        else if (last_check_reg != '0 && since_check < time_t'(check_interval_reg))
        begin
            res_word_next.status = STAT_INTERVAL;
        end
        else
        begin
            last_check_next = now;
            priority if (stage_word_reg.recovery_busy)
            begin
                res_word_next.status = STAT_BUSY;
            end
            else if (!stage_word_reg.has_vf_intent)
            begin
                drift_count_next     = '0;
                res_word_next.status = STAT_NO_INTENT;
            end
            else if (!stage_word_reg.hw_ready)
            begin
                drift_count_next     = '0;
                res_word_next.status = STAT_NOT_READY;
            end
            else if (!stage_word_reg.read_ok || !stage_word_reg.drift_seen)
            begin
                drift_count_next     = '0;
                res_word_next.status = STAT_NO_DRIFT;
            end
            else
            begin
                drift_count_next = count_inc;
                if (count_inc < confirm_reg)
                begin
                    res_word_next.status = STAT_PENDING;
                end
                else
                begin
                    if (window_start_reg == '0 || since_window > time_t'(window_reg))
                    begin
                        window_start_next = now;
                        win_count_eff     = '0;
                    end
                    window_count_next = win_count_eff;
                    priority if (win_count_eff >= max_per_window_reg)
                    begin
                        res_word_next.status = STAT_CAP;
                    end
                    else if (last_queue_reg != '0 && since_queue < time_t'(min_requeue_reg))
                    begin
                        res_word_next.status = STAT_BACKOFF;
                    end
                    else
                    begin
                        last_queue_next       = now;
                        window_count_next     = win_count_eff + 8'd1;
                        drift_count_next      = '0;
                        res_word_next.status  = STAT_QUEUED;
                        res_word_next.reapply = 1'b1;
                    end
                end
            end
        end

        res_word_next.consecutive      = drift_count_next;
        res_word_next.queued_in_window = window_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            res_valid_reg    <= 1'b0;
            last_check_reg   <= '0;
            drift_count_reg  <= '0;
            window_start_reg <= '0;
            window_count_reg <= '0;
            last_queue_reg   <= '0;
        end
        else
        begin
            if (chk_take)
                stage_valid_reg <= 1'b1;
            else if (stage_move)
                stage_valid_reg <= 1'b0;

            if (stage_move)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            if (stage_move)
            begin
                last_check_reg   <= last_check_next;
                drift_count_reg  <= drift_count_next;
                window_start_reg <= window_start_next;
                window_count_reg <= window_count_next;
                last_queue_reg   <= last_queue_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_take)
            stage_word_reg <= chk_word;
        if (stage_move)
            res_word_reg <= res_word_next;
    end

endmodule

// ===== verif/drift_reapply_rate_limiter_tb.sv =====
// Self-checking testbench for the drift reapply rate limiter: directed table, random checks, own predictor.
module drift_reapply_rate_limiter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import drrl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 20;

    // Flag patterns in word order: busy, intent, ready, read_ok, drift.
    localparam logic [4:0] F_DRIFT     = 5'b01111;
    localparam logic [4:0] F_CLEAN     = 5'b01110;
    localparam logic [4:0] F_BAD_READ  = 5'b01101;
    localparam logic [4:0] F_NO_INTENT = 5'b00111;
    localparam logic [4:0] F_NOT_READY = 5'b01011;
    localparam logic [4:0] F_BUSY      = 5'b11111;

    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        logic [31:0]  data;
        check_word_t  word;
        bit           fixed;
        result_word_t want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;
    logic chk_valid;
    logic chk_stall;
    check_word_t chk_word;
    logic res_valid;
    logic res_stall;
    result_word_t res_word;

    // Predictor copy of the registers and the check state.
    logic        en_cfg;
    logic [31:0] interval_cfg;
    logic [7:0]  confirm_cfg;
    logic [31:0] window_cfg;
    logic [7:0]  cap_cfg;
    logic [31:0] requeue_cfg;
    logic [47:0] seen_check_ms;
    logic [7:0]  drift_run;
    logic [47:0] win_start_ms;
    logic [7:0]  win_reapplies;
    logic [47:0] last_reapply_ms;

    result_word_t due_verdicts[$];
    step_row_t plan[$];
    logic [47:0] clock_ms;
    int send_idle;
    int recv_idle;
    int fail_count;
    int cycle_count;
    bit long_hold_req;

    drift_reapply_rate_limiter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chk_valid (chk_valid),
        .chk_stall (chk_stall),
        .chk_word  (chk_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always #5ns clk = ~clk;

    function automatic logic [47:0] span(input logic [47:0] now, input logic [47:0] then);
        return now - then;
    endfunction

    function automatic void judge_check(input check_word_t w, output result_word_t r);
        r.status = STAT_DISABLED;
        r.reapply = 1'b0;
        if (!en_cfg)
            r.status = STAT_DISABLED;
        else if (seen_check_ms != 0 && span(w.now_ms, seen_check_ms) < interval_cfg)
            r.status = STAT_INTERVAL;
        else
        begin
            seen_check_ms = w.now_ms;
            if (w.recovery_busy)
                r.status = STAT_BUSY;
            else if (!w.has_vf_intent)
            begin
                drift_run = 8'd0;
                r.status = STAT_NO_INTENT;
            end
            else if (!w.hw_ready)
            begin
                drift_run = 8'd0;
                r.status = STAT_NOT_READY;
            end
            else if (!w.read_ok || !w.drift_seen)
            begin
                drift_run = 8'd0;
                r.status = STAT_NO_DRIFT;
            end
            else
            begin
                if (drift_run != 8'hFF)
                    drift_run = drift_run + 8'd1;
                if (drift_run < confirm_cfg)
                    r.status = STAT_PENDING;
                else
                begin
                    if (win_start_ms == 0 || span(w.now_ms, win_start_ms) > window_cfg)
                    begin
                        win_start_ms = w.now_ms;
                        win_reapplies = 8'd0;
                    end
                    if (win_reapplies >= cap_cfg)
                        r.status = STAT_CAP;
                    else if (last_reapply_ms != 0
                             && span(w.now_ms, last_reapply_ms) < requeue_cfg)
                        r.status = STAT_BACKOFF;
                    else
                    begin
                        last_reapply_ms = w.now_ms;
                        win_reapplies = win_reapplies + 8'd1;
                        drift_run = 8'd0;
                        r.status = STAT_QUEUED;
                        r.reapply = 1'b1;
                    end
                end
            end
        end
        r.consecutive = drift_run;
        r.queued_in_window = win_reapplies;
    endfunction

    function automatic void add_check(input logic [47:0] t, input logic [4:0] flags);
        step_row_t row;
        row = '{default: '0};
        row.word = {t, flags};
        plan.push_back(row);
    endfunction

    function automatic void add_fixed(input logic [47:0] t, input logic [4:0] flags,
                                      input status_t st, input logic [7:0] run,
                                      input logic [7:0] queued);
        step_row_t row;
        row = '{default: '0};
        row.word = {t, flags};
        row.fixed = 1'b1;
        row.want.status = st;
        row.want.reapply = (st == STAT_QUEUED);
        row.want.consecutive = run;
        row.want.queued_in_window = queued;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] data);
        step_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_ENABLE:         en_cfg = data[0];
            CFG_CHECK_INTERVAL: interval_cfg = data;
            CFG_CONFIRM:        confirm_cfg = data[7:0];
            CFG_WINDOW:         window_cfg = data;
            CFG_MAX_PER_WINDOW: cap_cfg = data[7:0];
            CFG_MIN_REQUEUE:    requeue_cfg = data;
            default:            ;
        endcase
    endtask

    task automatic drain;
        chk_valid <= 1'b0;
        cfg_we <= 1'b0;
        do
            @(posedge clk);
        while (due_verdicts.size() != 0);
    endtask

    task automatic offer(input check_word_t w, input bit fixed, input result_word_t want);
        result_word_t got;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle)
        begin
            chk_valid <= 1'b0;
            @(posedge clk);
        end
        chk_valid <= 1'b1;
        chk_word <= w;
        do
            @(posedge clk);
        while (chk_stall);
        judge_check(w, got);
        due_verdicts.push_back(fixed ? want : got);
    endtask

    task automatic run_phase(input logic [31:0] interval, input logic [7:0] confirm,
                             input logic [31:0] window, input logic [7:0] cap,
                             input logic [31:0] requeue, input logic [31:0] step,
                             input int items, input int send_pct, input int recv_pct,
                             input int noise_pct, input int drift_pct,
                             input bit hold_first, input bit pause_mid);
        check_word_t w;
        logic [4:0] flags;
        int r;
        drain();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_CHECK_INTERVAL, interval);
        write_reg(CFG_CONFIRM, {24'd0, confirm});
        write_reg(CFG_WINDOW, window);
        write_reg(CFG_MAX_PER_WINDOW, {24'd0, cap});
        write_reg(CFG_MIN_REQUEUE, requeue);
        send_idle = send_pct;
        recv_idle = recv_pct;
        if (hold_first)
            long_hold_req = 1'b1;
        for (int n = 0; n < items; n++)
        begin
            if (pause_mid && n == items / 2)
                drain();
            r = $urandom_range(99);
            if (r < 3)
                clock_ms = {16'($urandom), $urandom};
            else if (r < 5)
                clock_ms = '0;
            else if (r < 25)
                clock_ms = clock_ms + $urandom_range(step);
            else if (r < 35)
                clock_ms = clock_ms + step;
            else
                clock_ms = clock_ms + step + $urandom_range(step / 2 + 1);
            if ($urandom_range(99) < noise_pct)
                flags = 5'($urandom_range(31));
            else
                flags = {4'b0111, $urandom_range(99) < drift_pct};
            w = {clock_ms, flags};
            offer(w, 1'b0, '0);
        end
    endtask

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            int hold_left;
            result_word_t want;
            @(posedge clk);
            if (res_valid && !res_stall)
            begin
                if (due_verdicts.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (res_word.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, res_word.status);
                        fail_count++;
                    end
                    if (res_word.reapply !== want.reapply)
                    begin
                        $error("reapply: expected %0d, actual %0d", want.reapply, res_word.reapply);
                        fail_count++;
                    end
                    if (res_word.consecutive !== want.consecutive)
                    begin
                        $error("consecutive: expected %0d, actual %0d",
                               want.consecutive, res_word.consecutive);
                        fail_count++;
                    end
                    if (res_word.queued_in_window !== want.queued_in_window)
                    begin
                        $error("queued_in_window: expected %0d, actual %0d",
                               want.queued_in_window, res_word.queued_in_window);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        chk_valid = 1'b0;
        chk_word = '0;
        fail_count = 0;
        long_hold_req = 1'b0;
        clock_ms = '0;
        send_idle = 15;
        recv_idle = 55;
        en_cfg = RST_ENABLE;
        interval_cfg = RST_CHECK_INTERVAL;
        confirm_cfg = RST_CONFIRM;
        window_cfg = RST_WINDOW;
        cap_cfg = RST_MAX_PER_WINDOW;
        requeue_cfg = RST_MIN_REQUEUE;
        seen_check_ms = '0;
        drift_run = '0;
        win_start_ms = '0;
        win_reapplies = '0;
        last_reapply_ms = '0;

        // A check at time zero stores zero, so the next check is not held by the interval.
        add_fixed(48'd0, F_BUSY, STAT_BUSY, 8'd0, 8'd0);
        add_fixed(48'd1, F_NO_INTENT, STAT_NO_INTENT, 8'd0, 8'd0);
        add_fixed(48'd2, F_DRIFT, STAT_INTERVAL, 8'd0, 8'd0);
        add_fixed(48'd5001, F_NOT_READY, STAT_NOT_READY, 8'd0, 8'd0);
        add_fixed(48'd10001, F_BAD_READ, STAT_NO_DRIFT, 8'd0, 8'd0);
        add_check(48'd15001, F_DRIFT);
        add_check(48'd20001, F_DRIFT);
        add_check(48'd25001, F_DRIFT);
        add_check(48'd30001, F_DRIFT);
        add_check(48'd35001, F_DRIFT);
        add_check(48'd40001, F_DRIFT);
        add_check(48'd45001, F_BUSY);
        add_check(48'hFFFF_FFFF_FFFF, F_DRIFT);
        add_check(48'd4999, F_DRIFT);
        add_check(48'd10000, F_CLEAN);
        add_cfg(CFG_ENABLE, 32'hFFFF_FFFE);
        add_check(48'h8000_0000_0000, F_DRIFT);
        add_cfg(CFG_ENABLE, 32'd1);
        add_cfg(CFG_CHECK_INTERVAL, 32'd0);
        add_cfg(CFG_CONFIRM, 32'd0);
        add_cfg(CFG_MAX_PER_WINDOW, 32'd0);
        add_check(48'd20000, F_DRIFT);
        add_cfg(CFG_MAX_PER_WINDOW, 32'hFFFF_FFFF);
        add_cfg(CFG_MIN_REQUEUE, 32'd0);
        add_cfg(CFG_WINDOW, 32'd0);
        add_cfg(3'd6, 32'hFFFF_FFFF);
        add_cfg(3'd7, 32'd0);
        add_check(48'd20000, F_DRIFT);
        add_check(48'd20000, F_DRIFT);
        add_check(48'd20001, F_DRIFT);
        add_check(48'd0, F_DRIFT);
        add_check(48'd0, F_DRIFT);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                offer(plan[i].word, plan[i].fixed, plan[i].want);
        end

        run_phase(32'd5000, 8'd3, 32'd600000, 8'd3, 32'd30000, 32'd5000,
                  300, 15, 55, 25, 80, 1'b0, 1'b1);
        run_phase(32'd10, 8'd1, 32'd300, 8'd2, 32'd40, 32'd10,
                  300, 55, 15, 25, 70, 1'b1, 1'b0);
        run_phase(32'd0, 8'd255, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF, 32'd1,
                  300, 0, 0, 0, 100, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  150, 0, 0, 30, 80, 1'b0, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/drrl_pkg.sv
rtl/core/drift_reapply_rate_limiter.sv
verif/drift_reapply_rate_limiter_tb.sv
